// File: sv/mvst_pkg.sv
// Shared constants, widths and record types of the minimum-variance spanning tree search.
package mvst_pkg;

  localparam int MAX_NODES   = 64;
  localparam int MAX_EDGES   = 1024;
  localparam int WEIGHT_BITS = 10;

  localparam int NODE_W = 7;                       // endpoint and node_count port width
  localparam int EIDX_W = $clog2(MAX_EDGES);       // edge address
  localparam int ECNT_W = EIDX_W + 1;              // edge count, holds MAX_EDGES
  localparam int NIDX_W = $clog2(MAX_NODES);       // parent table address (node - 1)
  localparam int NEED_W = $clog2(MAX_NODES);       // tree edge count, node_count - 1
  localparam int SUM_W  = $clog2((MAX_NODES - 1) * ((1 << WEIGHT_BITS) - 1) + 1);
  localparam int SQ1_W  = 2 * SUM_W;               // one squared deviation
  localparam int SQ_W   = 40;                      // key sum of one tree
  localparam int FRAC_W = 16;
  localparam int VAR_W  = 34;
  localparam int DIVD_W = SQ_W + FRAC_W;           // scaled dividend
  localparam int D3_W   = 3 * NEED_W;              // (node_count - 1)^3
  localparam int DCNT_W = $clog2(DIVD_W + 1);

  typedef struct packed {
    logic [NODE_W-1:0]      a;
    logic [NODE_W-1:0]      b;
    logic [WEIGHT_BITS-1:0] w;
  } edge_t;

  typedef struct packed {
    logic [EIDX_W-1:0]      idx;
    logic [WEIGHT_BITS-1:0] w;
  } sort_t;

endpackage

// File: sv/min_variance_spanning_tree.sv
// Top level: edge loading, sort, candidate-sum Kruskal passes and result scaling.
//
// Use: write node_count on the cfg channel (cfg_valid_i/cfg_ready_o, always
// ready) while the block is idle. Then issue one edge word per cycle with start
// while busy is low; the word is taken at that edge. Edges without last_edge_i
// keep the block idle, so a whole graph loads at one edge per cycle.
// The word with last_edge_i raises busy and starts the search:
//   - insertion sort of the stored edges by weight, a single-port walk over
//     the sort memory;
//   - one Kruskal pass per candidate sum between the n-1 smallest and n-1
//     largest weight totals. A pass clears the parent table, scans the sorted
//     list and then takes edges, each with a union-find walk in the parent
//     memory;
//   - the scaling division.
// The search time grows with edge count, node count and weight spread.
// One result word appears on variance_o/found_o with done_o for exactly one
// cycle; the receiver cannot stall, and busy is already low in that cycle.
// Reset puts the block idle with no edges and node_count = 2; the memories are
// not cleared, since only written entries are ever read.
module min_variance_spanning_tree (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mvst_pkg::NODE_W-1:0]      cfg_data_i,
  input  logic                             start,
  output logic                             busy,
  input  logic [mvst_pkg::NODE_W-1:0]      end_a_i,
  input  logic [mvst_pkg::NODE_W-1:0]      end_b_i,
  input  logic [mvst_pkg::WEIGHT_BITS-1:0] edge_weight_i,
  input  logic                             last_edge_i,
  output logic                             done_o,
  output logic [mvst_pkg::VAR_W-1:0]       variance_o,
  output logic                             found_o
);

  localparam int WB = mvst_pkg::WEIGHT_BITS;

  typedef enum logic [5:0] {
    S_IDLE, SO_TOP, SO_GET, SO_CMP, SO_PUT,
    SL_ISS, SL_ACC, SH_ISS, SH_ACC,
    P_INIT, P_RSCAN, P_RCHK,
    G_TOP, G_L1, G_L2, G_R0, G_R1, G_R2, G_DEC,
    T_TOP, T_FY, T_SEL, T_EDGE, T_FA, T_FB, T_SQ1, T_SQ2,
    P_END, D_A, D_B, D_GO, D_WAIT
  } state_e;

  // memories: edge words, sorted (index, weight) list, union-find links
  mvst_pkg::edge_t            edg_mem [mvst_pkg::MAX_EDGES];
  mvst_pkg::sort_t            srt_mem [mvst_pkg::MAX_EDGES];
  logic [mvst_pkg::NIDX_W-1:0] par_mem [mvst_pkg::MAX_NODES];

  logic                        edg_we, srt_we, par_we;
  logic [mvst_pkg::EIDX_W-1:0] edg_wa, edg_ra, srt_wa, srt_ra;
  logic [mvst_pkg::NIDX_W-1:0] par_wa, par_ra, par_wd;
  mvst_pkg::edge_t             edg_wd, edg_rd_q;
  mvst_pkg::sort_t             srt_wd, srt_rd_q;
  logic [mvst_pkg::NIDX_W-1:0] par_rd_q;

  always_ff @(posedge clk_i) begin
    if (edg_we) begin
      edg_mem[edg_wa] <= edg_wd;
    end
    edg_rd_q <= edg_mem[edg_ra];
  end

  always_ff @(posedge clk_i) begin
    if (srt_we) begin
      srt_mem[srt_wa] <= srt_wd;
    end
    srt_rd_q <= srt_mem[srt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (par_we) begin
      par_mem[par_wa] <= par_wd;
    end
    par_rd_q <= par_mem[par_ra];
  end

  state_e                      state_q, state_d;
  logic [mvst_pkg::NODE_W-1:0] ncfg_q, ncfg_d;
  logic [mvst_pkg::ECNT_W-1:0] total_q, total_d;
  logic [mvst_pkg::NODE_W-1:0] nused_q, nused_d;
  logic [mvst_pkg::NEED_W-1:0] need_q, need_d;
  logic [mvst_pkg::SQ_W-1:0]   best_q, best_d;
  logic [mvst_pkg::ECNT_W-1:0] i_q, i_d;
  logic [mvst_pkg::EIDX_W-1:0] j_q, j_d;
  logic [WB-1:0]               wi_q, wi_d;
  logic [mvst_pkg::NODE_W-1:0] k_q, k_d;
  logic [mvst_pkg::SUM_W-1:0]  lo_q, lo_d, hi_q, hi_d, s_q, s_d;
  logic [mvst_pkg::ECNT_W-1:0] lhi_q, lhi_d, rlo_q, rlo_d;
  logic [mvst_pkg::EIDX_W-1:0] ls_q, ls_d, re_q, re_d;
  logic [WB-1:0]               wl_q, wl_d, wr_q, wr_d;
  logic [mvst_pkg::SUM_W-1:0]  nwl_q, nwl_d, nwr_q, nwr_d;
  logic [mvst_pkg::ECNT_W-1:0] xp_q, xp_d, xend_q, xend_d, yp_q, yp_d, yend_q, yend_d;
  mvst_pkg::sort_t             ex_q, ex_d;
  logic [WB-1:0]               cw_q, cw_d;
  logic [mvst_pkg::NIDX_W-1:0] cur_q, cur_d, nb_q, nb_d, ra_q, ra_d;
  logic [mvst_pkg::SUM_W-1:0]  nw_q, nw_d, dd_q, dd_d;
  logic [mvst_pkg::NEED_W-1:0] taken_q, taken_d;
  logic [mvst_pkg::SQ_W-1:0]   sq_q, sq_d;
  logic [mvst_pkg::SUM_W-1:0]  pw_q, pw_d;
  logic [2*mvst_pkg::NEED_W-1:0] t_q, t_d;
  logic [mvst_pkg::D3_W-1:0]   d3_q, d3_d;
  logic [mvst_pkg::VAR_W-1:0]  var_q, var_d;
  logic                        found_q, found_d, done_q, done_d;

  logic                        div_start, div_done;
  logic [mvst_pkg::DIVD_W-1:0] div_quo;

  mvst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({best_q, {mvst_pkg::FRAC_W{1'b0}}}),
    .divisor_i  (d3_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    logic                        accept;
    logic [mvst_pkg::NODE_W-1:0] nclamp;
    logic [mvst_pkg::SUM_W-1:0]  prod;
    logic [mvst_pkg::SUM_W-1:0]  dl, dr;
    logic                        lok, rok, take_x;
    mvst_pkg::sort_t             sel;

    accept = start && (state_q == S_IDLE);
    nclamp = ncfg_q;
    prod   = '0;
    dl     = '0;
    dr     = '0;
    lok    = 1'b0;
    rok    = 1'b0;
    take_x = 1'b0;
    sel    = '0;

    state_d = state_q;  ncfg_d = ncfg_q;   total_d = total_q; nused_d = nused_q;
    need_d  = need_q;   best_d = best_q;   i_d = i_q;         j_d = j_q;
    wi_d    = wi_q;     k_d = k_q;         lo_d = lo_q;       hi_d = hi_q;
    s_d     = s_q;      lhi_d = lhi_q;     rlo_d = rlo_q;     ls_d = ls_q;
    re_d    = re_q;     wl_d = wl_q;       wr_d = wr_q;       nwl_d = nwl_q;
    nwr_d   = nwr_q;    xp_d = xp_q;       xend_d = xend_q;   yp_d = yp_q;
    yend_d  = yend_q;   ex_d = ex_q;       cw_d = cw_q;       cur_d = cur_q;
    nb_d    = nb_q;     ra_d = ra_q;       nw_d = nw_q;       dd_d = dd_q;
    taken_d = taken_q;  sq_d = sq_q;       pw_d = pw_q;       t_d = t_q;
    d3_d    = d3_q;     var_d = var_q;     found_d = found_q; done_d = 1'b0;

    edg_we = 1'b0; edg_wa = '0; edg_wd = '0; edg_ra = '0;
    srt_we = 1'b0; srt_wa = '0; srt_wd = '0; srt_ra = '0;
    par_we = 1'b0; par_wa = '0; par_wd = '0; par_ra = '0;
    div_start = 1'b0;

    if (cfg_valid_i) begin
      ncfg_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (total_q < mvst_pkg::ECNT_W'(mvst_pkg::MAX_EDGES)) begin
            edg_we  = 1'b1;
            edg_wa  = total_q[mvst_pkg::EIDX_W-1:0];
            edg_wd  = '{a: end_a_i, b: end_b_i, w: edge_weight_i};
            total_d = total_q + 1'b1;
          end
          if (last_edge_i) begin
            if (ncfg_q < mvst_pkg::NODE_W'(2)) begin
              nclamp = mvst_pkg::NODE_W'(2);
            end else if (ncfg_q > mvst_pkg::NODE_W'(mvst_pkg::MAX_NODES)) begin
              nclamp = mvst_pkg::NODE_W'(mvst_pkg::MAX_NODES);
            end
            nused_d = nclamp;
            need_d  = mvst_pkg::NEED_W'(nclamp - 1'b1);
            best_d  = '1;
            i_d     = '0;
            state_d = SO_TOP;
          end
        end
      end

      // insertion sort, stable on equal weights
      SO_TOP: begin
        if (i_q == total_q) begin
          lo_d = '0;
          hi_d = '0;
          k_d  = '0;
          if (total_q < mvst_pkg::ECNT_W'(need_q)) begin
            var_d   = '0;
            found_d = 1'b0;
            done_d  = 1'b1;
            total_d = '0;
            best_d  = '1;
            state_d = S_IDLE;
          end else begin
            state_d = SL_ISS;
          end
        end else begin
          edg_ra  = i_q[mvst_pkg::EIDX_W-1:0];
          state_d = SO_GET;
        end
      end
      SO_GET: begin
        wi_d = edg_rd_q.w;
        j_d  = i_q[mvst_pkg::EIDX_W-1:0];
        if (i_q == '0) begin
          state_d = SO_PUT;
        end else begin
          srt_ra  = i_q[mvst_pkg::EIDX_W-1:0] - 1'b1;
          state_d = SO_CMP;
        end
      end
      SO_CMP: begin
        if (srt_rd_q.w > wi_q) begin
          srt_we = 1'b1;
          srt_wa = j_q;
          srt_wd = srt_rd_q;
          j_d    = j_q - 1'b1;
          if (j_q == mvst_pkg::EIDX_W'(1)) begin
            state_d = SO_PUT;
          end else begin
            srt_ra = j_q - mvst_pkg::EIDX_W'(2);
          end
        end else begin
          state_d = SO_PUT;
        end
      end
      SO_PUT: begin
        srt_we  = 1'b1;
        srt_wa  = j_q;
        srt_wd  = '{idx: i_q[mvst_pkg::EIDX_W-1:0], w: wi_q};
        i_d     = i_q + 1'b1;
        state_d = SO_TOP;
      end

      // candidate range: n-1 smallest and n-1 largest weights
      SL_ISS: begin
        srt_ra  = mvst_pkg::EIDX_W'(k_q);
        state_d = SL_ACC;
      end
      SL_ACC: begin
        lo_d = lo_q + mvst_pkg::SUM_W'(srt_rd_q.w);
        k_d  = k_q + 1'b1;
        if ((k_q + 1'b1) < mvst_pkg::NODE_W'(need_q)) begin
          srt_ra = mvst_pkg::EIDX_W'(k_q + 1'b1);
        end else begin
          k_d     = '0;
          state_d = SH_ISS;
        end
      end
      SH_ISS: begin
        srt_ra  = mvst_pkg::EIDX_W'(total_q - mvst_pkg::ECNT_W'(need_q)
                                    + mvst_pkg::ECNT_W'(k_q));
        state_d = SH_ACC;
      end
      SH_ACC: begin
        hi_d = hi_q + mvst_pkg::SUM_W'(srt_rd_q.w);
        k_d  = k_q + 1'b1;
        if ((k_q + 1'b1) < mvst_pkg::NODE_W'(need_q)) begin
          srt_ra = mvst_pkg::EIDX_W'(total_q - mvst_pkg::ECNT_W'(need_q)
                                     + mvst_pkg::ECNT_W'(k_q + 1'b1));
        end else begin
          k_d     = '0;
          s_d     = lo_q;
          state_d = P_INIT;
        end
      end

      // one pass per candidate sum: clear links, then split at need*w > s
      P_INIT: begin
        par_we = 1'b1;
        par_wa = mvst_pkg::NIDX_W'(k_q);
        par_wd = mvst_pkg::NIDX_W'(k_q);
        k_d    = k_q + 1'b1;
        if ((k_q + 1'b1) == nused_q) begin
          taken_d = '0;
          sq_d    = '0;
          pw_d    = '0;
          rlo_d   = '0;
          state_d = P_RSCAN;
        end
      end
      P_RSCAN: begin
        srt_ra  = rlo_q[mvst_pkg::EIDX_W-1:0];
        state_d = P_RCHK;
      end
      P_RCHK: begin
        prod = mvst_pkg::SUM_W'(need_q) * mvst_pkg::SUM_W'(srt_rd_q.w);
        if (prod <= s_q) begin
          rlo_d = rlo_q + 1'b1;
          lhi_d = rlo_q + 1'b1;
          if ((rlo_q + 1'b1) < total_q) begin
            srt_ra = mvst_pkg::EIDX_W'(rlo_q + 1'b1);
          end else begin
            state_d = G_TOP;
          end
        end else begin
          lhi_d   = rlo_q;
          state_d = G_TOP;
        end
      end

      // find the weight group on each side of the split
      G_TOP: begin
        if (taken_q == need_q || (lhi_q == '0 && rlo_q == total_q)) begin
          state_d = P_END;
        end else if (lhi_q != '0) begin
          srt_ra  = mvst_pkg::EIDX_W'(lhi_q - 1'b1);
          state_d = G_L1;
        end else begin
          state_d = G_R0;
        end
      end
      G_L1: begin
        wl_d  = srt_rd_q.w;
        nwl_d = mvst_pkg::SUM_W'(need_q) * mvst_pkg::SUM_W'(srt_rd_q.w);
        ls_d  = mvst_pkg::EIDX_W'(lhi_q - 1'b1);
        if (lhi_q > mvst_pkg::ECNT_W'(1)) begin
          srt_ra  = mvst_pkg::EIDX_W'(lhi_q - mvst_pkg::ECNT_W'(2));
          state_d = G_L2;
        end else begin
          state_d = G_R0;
        end
      end
      G_L2: begin
        if (srt_rd_q.w == wl_q) begin
          ls_d = ls_q - 1'b1;
          if (ls_q > mvst_pkg::EIDX_W'(1)) begin
            srt_ra = ls_q - mvst_pkg::EIDX_W'(2);
          end else begin
            state_d = G_R0;
          end
        end else begin
          state_d = G_R0;
        end
      end
      G_R0: begin
        if (rlo_q < total_q) begin
          srt_ra  = rlo_q[mvst_pkg::EIDX_W-1:0];
          state_d = G_R1;
        end else begin
          state_d = G_DEC;
        end
      end
      G_R1: begin
        wr_d  = srt_rd_q.w;
        nwr_d = mvst_pkg::SUM_W'(need_q) * mvst_pkg::SUM_W'(srt_rd_q.w);
        re_d  = rlo_q[mvst_pkg::EIDX_W-1:0];
        if ((rlo_q + 1'b1) < total_q) begin
          srt_ra  = mvst_pkg::EIDX_W'(rlo_q + 1'b1);
          state_d = G_R2;
        end else begin
          state_d = G_DEC;
        end
      end
      G_R2: begin
        if (srt_rd_q.w == wr_q) begin
          re_d = re_q + 1'b1;
          if ((mvst_pkg::ECNT_W'(re_q) + mvst_pkg::ECNT_W'(2)) < total_q) begin
            srt_ra = re_q + mvst_pkg::EIDX_W'(2);
          end else begin
            state_d = G_DEC;
          end
        end else begin
          state_d = G_DEC;
        end
      end
      // nearer group first; equal distance merges both by input order
      G_DEC: begin
        lok    = lhi_q != '0;
        rok    = rlo_q < total_q;
        dl     = s_q - nwl_q;
        dr     = nwr_q - s_q;
        xp_d   = mvst_pkg::ECNT_W'(ls_q);
        xend_d = lhi_q;
        yp_d   = rlo_q;
        yend_d = mvst_pkg::ECNT_W'(re_q) + 1'b1;
        if (!rok || (lok && dl < dr)) begin
          yend_d = rlo_q;
          lhi_d  = mvst_pkg::ECNT_W'(ls_q);
        end else if (!lok || dr < dl) begin
          xend_d = mvst_pkg::ECNT_W'(ls_q);
          rlo_d  = mvst_pkg::ECNT_W'(re_q) + 1'b1;
        end else begin
          lhi_d  = mvst_pkg::ECNT_W'(ls_q);
          rlo_d  = mvst_pkg::ECNT_W'(re_q) + 1'b1;
        end
        state_d = T_TOP;
      end

      // Kruskal step on the next edge
      T_TOP: begin
        if (taken_q == need_q || (xp_q == xend_q && yp_q == yend_q)) begin
          state_d = G_TOP;
        end else begin
          srt_ra  = xp_q[mvst_pkg::EIDX_W-1:0];
          state_d = T_FY;
        end
      end
      T_FY: begin
        ex_d    = srt_rd_q;
        srt_ra  = yp_q[mvst_pkg::EIDX_W-1:0];
        state_d = T_SEL;
      end
      T_SEL: begin
        take_x = (yp_q == yend_q) || (xp_q != xend_q && ex_q.idx < srt_rd_q.idx);
        sel    = take_x ? ex_q : srt_rd_q;
        if (take_x) begin
          xp_d = xp_q + 1'b1;
        end else begin
          yp_d = yp_q + 1'b1;
        end
        cw_d    = sel.w;
        edg_ra  = sel.idx;
        state_d = T_EDGE;
      end
      T_EDGE: begin
        if (edg_rd_q.a == '0 || edg_rd_q.a > nused_q ||
            edg_rd_q.b == '0 || edg_rd_q.b > nused_q) begin
          state_d = T_TOP;
        end else begin
          cur_d   = mvst_pkg::NIDX_W'(edg_rd_q.a - 1'b1);
          nb_d    = mvst_pkg::NIDX_W'(edg_rd_q.b - 1'b1);
          par_ra  = mvst_pkg::NIDX_W'(edg_rd_q.a - 1'b1);
          state_d = T_FA;
        end
      end
      T_FA: begin
        if (par_rd_q == cur_q) begin
          ra_d    = cur_q;
          cur_d   = nb_q;
          par_ra  = nb_q;
          state_d = T_FB;
        end else begin
          cur_d  = par_rd_q;
          par_ra = par_rd_q;
        end
      end
      T_FB: begin
        if (par_rd_q == cur_q) begin
          if (cur_q == ra_q) begin
            state_d = T_TOP;
          end else begin
            par_we  = 1'b1;
            par_wa  = cur_q;
            par_wd  = ra_q;
            nw_d    = mvst_pkg::SUM_W'(need_q) * mvst_pkg::SUM_W'(cw_q);
            state_d = T_SQ1;
          end
        end else begin
          cur_d  = par_rd_q;
          par_ra = par_rd_q;
        end
      end
      T_SQ1: begin
        dd_d    = (nw_q >= s_q) ? (nw_q - s_q) : (s_q - nw_q);
        state_d = T_SQ2;
      end
      T_SQ2: begin
        sq_d    = sq_q + mvst_pkg::SQ_W'(mvst_pkg::SQ1_W'(dd_q) * mvst_pkg::SQ1_W'(dd_q));
        pw_d    = pw_q + mvst_pkg::SUM_W'(cw_q);
        taken_d = taken_q + 1'b1;
        state_d = T_TOP;
      end

      P_END: begin
        if (taken_q == need_q && pw_q == s_q && sq_q < best_q) begin
          best_d = sq_q;
        end
        if (s_q == hi_q) begin
          state_d = D_A;
        end else begin
          s_d     = s_q + 1'b1;
          k_d     = '0;
          state_d = P_INIT;
        end
      end

      // variance = best / need^3 with 16 fraction bits
      D_A: begin
        if (best_q == '1) begin
          var_d   = '0;
          found_d = 1'b0;
          done_d  = 1'b1;
          total_d = '0;
          state_d = S_IDLE;
        end else begin
          t_d     = (2*mvst_pkg::NEED_W)'(need_q) * (2*mvst_pkg::NEED_W)'(need_q);
          state_d = D_B;
        end
      end
      D_B: begin
        d3_d    = mvst_pkg::D3_W'(t_q) * mvst_pkg::D3_W'(need_q);
        state_d = D_GO;
      end
      D_GO: begin
        div_start = 1'b1;
        state_d   = D_WAIT;
      end
      D_WAIT: begin
        if (div_done) begin
          if (|div_quo[mvst_pkg::DIVD_W-1:mvst_pkg::VAR_W]) begin
            var_d = '1;
          end else begin
            var_d = div_quo[mvst_pkg::VAR_W-1:0];
          end
          found_d = 1'b1;
          done_d  = 1'b1;
          total_d = '0;
          best_d  = '1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;  ncfg_q <= mvst_pkg::NODE_W'(2); total_q <= '0;
      nused_q <= '0;      need_q <= '0;    best_q <= '1;   i_q <= '0;
      j_q <= '0;          wi_q <= '0;      k_q <= '0;      lo_q <= '0;
      hi_q <= '0;         s_q <= '0;       lhi_q <= '0;    rlo_q <= '0;
      ls_q <= '0;         re_q <= '0;      wl_q <= '0;     wr_q <= '0;
      nwl_q <= '0;        nwr_q <= '0;     xp_q <= '0;     xend_q <= '0;
      yp_q <= '0;         yend_q <= '0;    ex_q <= '0;     cw_q <= '0;
      cur_q <= '0;        nb_q <= '0;      ra_q <= '0;     nw_q <= '0;
      dd_q <= '0;         taken_q <= '0;   sq_q <= '0;     pw_q <= '0;
      t_q <= '0;          d3_q <= '0;      var_q <= '0;    found_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d; ncfg_q <= ncfg_d; total_q <= total_d;
      nused_q <= nused_d; need_q <= need_d; best_q <= best_d; i_q <= i_d;
      j_q <= j_d;         wi_q <= wi_d;     k_q <= k_d;     lo_q <= lo_d;
      hi_q <= hi_d;       s_q <= s_d;       lhi_q <= lhi_d; rlo_q <= rlo_d;
      ls_q <= ls_d;       re_q <= re_d;     wl_q <= wl_d;   wr_q <= wr_d;
      nwl_q <= nwl_d;     nwr_q <= nwr_d;   xp_q <= xp_d;   xend_q <= xend_d;
      yp_q <= yp_d;       yend_q <= yend_d; ex_q <= ex_d;   cw_q <= cw_d;
      cur_q <= cur_d;     nb_q <= nb_d;     ra_q <= ra_d;   nw_q <= nw_d;
      dd_q <= dd_d;       taken_q <= taken_d; sq_q <= sq_d; pw_q <= pw_d;
      t_q <= t_d;         d3_q <= d3_d;     var_q <= var_d; found_q <= found_d;
      done_q <= done_d;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = state_q != S_IDLE;
  assign done_o      = done_q;
  assign variance_o  = var_q;
  assign found_o     = found_q;

endmodule

// File: sv/mvst_div.sv
// Restoring divider, one quotient bit per cycle, for the final variance scaling.
module mvst_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mvst_pkg::DIVD_W-1:0] dividend_i,
  input  logic [mvst_pkg::D3_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [mvst_pkg::DIVD_W-1:0] quotient_o
);

  logic                        run_q;
  logic                        done_q;
  logic [mvst_pkg::DCNT_W-1:0] cnt_q;
  logic [mvst_pkg::D3_W-1:0]   rem_q;
  logic [mvst_pkg::D3_W-1:0]   dvs_q;
  logic [mvst_pkg::DIVD_W-1:0] qr_q;
  logic [mvst_pkg::D3_W:0]     rem_sh;
  logic                        fits;

  assign rem_sh = {rem_q, qr_q[mvst_pkg::DIVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      qr_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        rem_q <= '0;
        dvs_q <= divisor_i;
        qr_q  <= dividend_i;
      end else if (run_q) begin
        if (fits) begin
          rem_q <= mvst_pkg::D3_W'(rem_sh - {1'b0, dvs_q});
        end else begin
          rem_q <= rem_sh[mvst_pkg::D3_W-1:0];
        end
        qr_q  <= {qr_q[mvst_pkg::DIVD_W-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == mvst_pkg::DCNT_W'(mvst_pkg::DIVD_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = qr_q;

endmodule

// File: sv/mvst_chk.sv
// Port-level checker of the spanning tree search, bound to the top level.
module mvst_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       last_edge_i,
  input logic                       done_o,
  input logic                       found_o,
  input logic [mvst_pkg::VAR_W-1:0] variance_o
);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result word while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (variance_o == '0)) else $error("nonzero variance without tree");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !last_edge_i) |=> !busy) else $error("busy after plain edge word");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_edge_i) |=> (busy && !done_o)) else $error("search did not start");

endmodule

bind min_variance_spanning_tree mvst_chk u_mvst_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .last_edge_i (last_edge_i),
  .done_o      (done_o),
  .found_o     (found_o),
  .variance_o  (variance_o)
);
